### rtl/ufss_pkg.sv
// Shared constants, codes and types for the union-find engine with set sums.
`default_nettype none

package ufss_pkg;

   localparam int NODES   = 1024;
   localparam int NODE_W  = 10;
   localparam int LINK_W  = 12;
   localparam int SUM_W   = 42;
   localparam int VALUE_W = 32;
   localparam int OP_W    = 2;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_UNITE = 2'd1,
      OP_SAME  = 2'd2,
      OP_SUM   = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_FIND_RD,
      ST_FIND,
      ST_PATH_RD,
      ST_PATH,
      ST_JOIN_A,
      ST_JOIN_B,
      ST_JOIN_WR,
      ST_JOIN_LINK,
      ST_SUM,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PASS_A,
      PASS_B,
      PASS_A_AGAIN
   } pass_type;

   typedef struct packed {
      logic [NODE_W-1:0] keep;
      logic [NODE_W-1:0] drop;
      logic [LINK_W-1:0] link;
      logic [SUM_W-1:0]  total;
   } merge_type;

endpackage

`default_nettype wire

### rtl/union_find_with_set_sums.sv
// Top level of the union-find engine: link and sum memories and the operation sequencer.
`default_nettype none

// Disjoint-set engine over 1024 nodes with union by size, path compression
// and a per-set sum of member values. After reset the block initializes its
// memories, one entry per cycle, with req_ready low. Requests are handled
// one at a time. A load writes the node's link and sum and then reads the
// sum back for its result. Every root search walks the parent links through
// the single read port of the link memory, one link per cycle, and then
// walks the path again to compress it. A sum query makes one search, a
// same-set query or a unite of two nodes already in one set two searches,
// and a unite that joins two sets three searches. The result waits in an
// output register, so a new request is taken while an earlier result has
// not yet been collected; a finished result waits until that register is
// free, and the block takes no request meanwhile.
module union_find_with_set_sums (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [ufss_pkg::OP_W-1:0]     req_opcode,
   input  wire logic [ufss_pkg::NODE_W-1:0]   req_node_a,
   input  wire logic [ufss_pkg::NODE_W-1:0]   req_node_b,
   input  wire logic [ufss_pkg::VALUE_W-1:0]  req_node_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_merged,
   output logic                               rsp_same_set,
   output logic [ufss_pkg::NODE_W-1:0]        rsp_root_index,
   output logic [ufss_pkg::SUM_W-1:0]         rsp_set_sum
);
   import ufss_pkg::*;

   logic [LINK_W-1:0] link_mem [NODES];
   logic [SUM_W-1:0]  sum_mem  [NODES];

   state_type         state_ff, state_in;
   pass_type          pass_ff, pass_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;

   opcode_type         op_ff, op_in;
   logic [NODE_W-1:0]  a_ff, a_in;
   logic [NODE_W-1:0]  b_ff, b_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [NODE_W-1:0]  cur_ff, cur_in;
   logic [NODE_W-1:0]  root_ff, root_in;
   logic [NODE_W-1:0]  ra_ff, ra_in;
   logic [NODE_W-1:0]  rb_ff, rb_in;
   logic [LINK_W-1:0]  link_a_ff, link_a_in;
   logic [SUM_W-1:0]   sum_a_ff, sum_a_in;
   logic [NODE_W-1:0]  keep_ff, keep_in;
   logic [NODE_W-1:0]  drop_ff, drop_in;
   logic               merged_ff, merged_in;
   logic               same_ff, same_in;
   logic               rsp_merged_ff, rsp_merged_in;
   logic               rsp_same_ff, rsp_same_in;
   logic [NODE_W-1:0]  rsp_root_ff, rsp_root_in;
   logic [SUM_W-1:0]   rsp_sum_ff, rsp_sum_in;

   logic [LINK_W-1:0] link_rd_ff;
   logic [SUM_W-1:0]  sum_rd_ff;
   logic [NODE_W-1:0] link_ra, link_wa, sum_ra, sum_wa;
   logic [LINK_W-1:0] link_wd;
   logic [SUM_W-1:0]  sum_wd;
   logic              link_we, sum_we;

   logic [NODE_W-1:0] start_node;
   logic [NODE_W-1:0] parent;
   logic              find_done;
   logic [NODE_W-1:0] found_root;
   merge_type         merge;

   ufss_merge u_merge (
      .root_a (ra_ff),
      .root_b (rb_ff),
      .link_a (link_a_ff),
      .link_b (link_rd_ff),
      .sum_a  (sum_a_ff),
      .sum_b  (sum_rd_ff),
      .merge  (merge)
   );

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      link_rd_ff <= link_mem[link_ra];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_wa] <= sum_wd;
      end
      sum_rd_ff <= sum_mem[sum_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pass_ff      <= PASS_A;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      value_ff      <= value_in;
      cur_ff        <= cur_in;
      root_ff       <= root_in;
      ra_ff         <= ra_in;
      rb_ff         <= rb_in;
      link_a_ff     <= link_a_in;
      sum_a_ff      <= sum_a_in;
      keep_ff       <= keep_in;
      drop_ff       <= drop_in;
      merged_ff     <= merged_in;
      same_ff       <= same_in;
      rsp_merged_ff <= rsp_merged_in;
      rsp_same_ff   <= rsp_same_in;
      rsp_root_ff   <= rsp_root_in;
      rsp_sum_ff    <= rsp_sum_in;
   end

   always_comb begin
      state_in      = state_ff;
      pass_in       = pass_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      op_in         = op_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      value_in      = value_ff;
      cur_in        = cur_ff;
      root_in       = root_ff;
      ra_in         = ra_ff;
      rb_in         = rb_ff;
      link_a_in     = link_a_ff;
      sum_a_in      = sum_a_ff;
      keep_in       = keep_ff;
      drop_in       = drop_ff;
      merged_in     = merged_ff;
      same_in       = same_ff;
      rsp_merged_in = rsp_merged_ff;
      rsp_same_in   = rsp_same_ff;
      rsp_root_in   = rsp_root_ff;
      rsp_sum_in    = rsp_sum_ff;

      req_ready  = 1'b0;
      link_ra    = cur_ff;
      sum_ra     = ra_ff;
      link_we    = 1'b0;
      link_wa    = cur_ff;
      link_wd    = {{(LINK_W-NODE_W){1'b0}}, root_ff};
      sum_we     = 1'b0;
      sum_wa     = a_ff;
      sum_wd     = {{(SUM_W-VALUE_W){1'b0}}, value_ff};
      start_node = (pass_ff == PASS_B) ? b_ff : a_ff;
      parent     = link_rd_ff[NODE_W-1:0];
      find_done  = 1'b0;
      found_root = root_ff;

      case (state_ff)
         ST_CLEAR: begin
            link_we = 1'b1;
            link_wa = clr_ff;
            link_wd = '1;
            sum_we  = 1'b1;
            sum_wa  = clr_ff;
            sum_wd  = '0;
            clr_in  = clr_ff + NODE_W'(1);
            if (clr_ff == NODE_W'(NODES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = opcode_type'(req_opcode);
               a_in      = req_node_a;
               b_in      = req_node_b;
               value_in  = req_node_value;
               merged_in = 1'b0;
               same_in   = 1'b0;
               pass_in   = PASS_A;
               if (opcode_type'(req_opcode) == OP_LOAD) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_FIND_RD;
               end
            end
         end
         ST_LOAD: begin
            link_we  = 1'b1;
            link_wa  = a_ff;
            link_wd  = '1;
            sum_we   = 1'b1;
            ra_in    = a_ff;
            state_in = ST_SUM;
         end
         ST_FIND_RD: begin
            link_ra  = start_node;
            cur_in   = start_node;
            state_in = ST_FIND;
         end
         ST_FIND: begin
            if (link_rd_ff[LINK_W-1]) begin
               root_in  = cur_ff;
               cur_in   = start_node;
               state_in = ST_PATH_RD;
            end else begin
               link_ra = parent;
               cur_in  = parent;
            end
         end
         ST_PATH_RD: begin
            if (cur_ff == root_ff) begin
               find_done = 1'b1;
            end else begin
               state_in = ST_PATH;
            end
         end
         ST_PATH: begin
            link_we = 1'b1;
            cur_in  = parent;
            if (parent == root_ff) begin
               find_done = 1'b1;
            end else begin
               link_ra = parent;
            end
         end
         ST_JOIN_A: begin
            link_ra  = ra_ff;
            state_in = ST_JOIN_B;
         end
         ST_JOIN_B: begin
            link_a_in = link_rd_ff;
            sum_a_in  = sum_rd_ff;
            link_ra   = rb_ff;
            sum_ra    = rb_ff;
            state_in  = ST_JOIN_WR;
         end
         ST_JOIN_WR: begin
            link_we  = 1'b1;
            link_wa  = merge.keep;
            link_wd  = merge.link;
            sum_we   = 1'b1;
            sum_wa   = merge.keep;
            sum_wd   = merge.total;
            keep_in  = merge.keep;
            drop_in  = merge.drop;
            state_in = ST_JOIN_LINK;
         end
         ST_JOIN_LINK: begin
            link_we   = 1'b1;
            link_wa   = drop_ff;
            link_wd   = {{(LINK_W-NODE_W){1'b0}}, keep_ff};
            merged_in = 1'b1;
            pass_in   = PASS_A_AGAIN;
            state_in  = ST_FIND_RD;
         end
         ST_SUM: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_merged_in = merged_ff;
               rsp_same_in   = same_ff;
               rsp_root_in   = ra_ff;
               rsp_sum_in    = sum_rd_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (find_done) begin
         case (pass_ff)
            PASS_A: begin
               ra_in = found_root;
               if (op_ff == OP_SUM) begin
                  state_in = ST_SUM;
               end else begin
                  pass_in  = PASS_B;
                  state_in = ST_FIND_RD;
               end
            end
            PASS_B: begin
               rb_in = found_root;
               if (op_ff == OP_UNITE) begin
                  same_in = 1'b1;
                  if (ra_ff == found_root) begin
                     state_in = ST_SUM;
                  end else begin
                     state_in = ST_JOIN_A;
                  end
               end else begin
                  same_in  = (ra_ff == found_root);
                  state_in = ST_SUM;
               end
            end
            default: begin
               ra_in    = found_root;
               state_in = ST_SUM;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_merged     = rsp_merged_ff;
   assign rsp_same_set   = rsp_same_ff;
   assign rsp_root_index = rsp_root_ff;
   assign rsp_set_sum    = rsp_sum_ff;

endmodule

`default_nettype wire

### rtl/ufss_merge.sv
// Union by size: picks the surviving root and forms the saturated size and sum.
`default_nettype none

module ufss_merge (
   input  wire logic [ufss_pkg::NODE_W-1:0] root_a,
   input  wire logic [ufss_pkg::NODE_W-1:0] root_b,
   input  wire logic [ufss_pkg::LINK_W-1:0] link_a,
   input  wire logic [ufss_pkg::LINK_W-1:0] link_b,
   input  wire logic [ufss_pkg::SUM_W-1:0]  sum_a,
   input  wire logic [ufss_pkg::SUM_W-1:0]  sum_b,
   output ufss_pkg::merge_type              merge
);
   import ufss_pkg::*;

   logic [LINK_W-1:0] size_a;
   logic [LINK_W-1:0] size_b;
   logic [LINK_W:0]   size_sum;
   logic [LINK_W-1:0] size_new;
   logic [SUM_W:0]    total_sum;

   always_comb begin
      size_a    = ~link_a + LINK_W'(1);
      size_b    = ~link_b + LINK_W'(1);
      size_sum  = {1'b0, size_a} + {1'b0, size_b};
      if (size_sum > (LINK_W+1)'(NODES)) begin
         size_new = LINK_W'(NODES);
      end else begin
         size_new = size_sum[LINK_W-1:0];
      end
      total_sum = {1'b0, sum_a} + {1'b0, sum_b};

      if (size_a < size_b) begin
         merge.keep = root_b;
         merge.drop = root_a;
      end else begin
         merge.keep = root_a;
         merge.drop = root_b;
      end
      merge.link = ~size_new + LINK_W'(1);
      if (total_sum[SUM_W]) begin
         merge.total = '1;
      end else begin
         merge.total = total_sum[SUM_W-1:0];
      end
   end

endmodule

`default_nettype wire

### rtl/ufss_checker.sv
// Port-level checks on the union-find engine, bound to its top level.
`default_nettype none

module ufss_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic                          rsp_merged,
   input wire logic                          rsp_same_set,
   input wire logic [ufss_pkg::NODE_W-1:0]   rsp_root_index,
   input wire logic [ufss_pkg::SUM_W-1:0]    rsp_set_sum
);

   a_reset_init: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("Block not initializing after reset.");

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("Second request taken while one is in progress.");

   a_merged_same: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_merged) |-> rsp_same_set)
      else $error("Joined sets reported as different sets.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_merged)
         && $stable(rsp_same_set) && $stable(rsp_root_index) && $stable(rsp_set_sum))
      else $error("Stalled result changed before it was taken.");

endmodule

bind union_find_with_set_sums ufss_checker u_checker (.*);

`default_nettype wire

### tb/union_find_with_set_sums_tb.sv
// Self-checking testbench for the union-find engine with per-set sums.
`default_nettype none

module union_find_with_set_sums_tb;
   import ufss_pkg::*;

   localparam int CYCLE_LIMIT   = 2000000;
   localparam int DRAIN_CYCLES  = 100;
   localparam int LONG_HOLD     = 300;
   localparam int HOLD_AFTER    = 40;
   localparam int RANDOM_ITEMS  = 125;
   localparam int CHAIN_NODES   = 64;

   typedef struct packed {
      logic              merged;
      logic              same_set;
      logic [NODE_W-1:0] root_index;
      logic [SUM_W-1:0]  set_sum;
   } set_answer_type;

   class disjoint_set_scoreboard;
      int               link_or_size [NODES];
      logic [SUM_W-1:0] root_total [NODES];
      set_answer_type   pending_results [$];
      int               mismatches;
      int               checked;

      function new();
         for (int i = 0; i < NODES; i++) begin
            link_or_size[i] = -1;
            root_total[i] = '0;
         end
         mismatches = 0;
         checked = 0;
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction

      // Follows parent links to the root and then points the whole path at it.
      function int root_of(int node);
         int root;
         int hop;
         int steps;
         root = node;
         steps = 0;
         while (link_or_size[root] >= 0 && steps < NODES) begin
            root = link_or_size[root] % NODES;
            steps++;
         end
         steps = 0;
         while (node != root && link_or_size[node] >= 0 && steps < NODES) begin
            hop = link_or_size[node] % NODES;
            link_or_size[node] = root;
            node = hop;
            steps++;
         end
         return root;
      endfunction

      function bit join_roots(int a, int b);
         int               ra;
         int               rb;
         int               keep;
         int               drop;
         int               size;
         logic [SUM_W:0]   total;
         ra = root_of(a);
         rb = root_of(b);
         if (ra == rb)
            return 1'b0;
         if (-link_or_size[ra] < -link_or_size[rb]) begin
            keep = rb;
            drop = ra;
         end else begin
            keep = ra;
            drop = rb;
         end
         size = -link_or_size[keep] - link_or_size[drop];
         if (size > NODES)
            size = NODES;
         total = {1'b0, root_total[keep]} + {1'b0, root_total[drop]};
         if (total[SUM_W])
            total = {1'b0, {SUM_W{1'b1}}};
         link_or_size[keep] = -size;
         root_total[keep] = total[SUM_W-1:0];
         link_or_size[drop] = keep;
         return 1'b1;
      endfunction

      function void note_request(opcode_type op, logic [NODE_W-1:0] node_a,
                                 logic [NODE_W-1:0] node_b, logic [VALUE_W-1:0] value);
         set_answer_type answer;
         int             a;
         int             b;
         int             root;
         answer = '0;
         a = int'(node_a);
         b = int'(node_b);
         case (op)
            OP_LOAD: begin
               link_or_size[a] = -1;
               root_total[a] = SUM_W'(value);
               root = a;
            end
            OP_UNITE: begin
               answer.merged = join_roots(a, b);
               root = root_of(a);
               answer.same_set = 1'b1;
            end
            OP_SAME: begin
               root = root_of(a);
               answer.same_set = (root == root_of(b));
            end
            default: begin
               root = root_of(a);
            end
         endcase
         answer.root_index = NODE_W'(root);
         answer.set_sum = root_total[root];
         pending_results = {pending_results, answer};
      endfunction

      function void check_response(logic merged, logic same_set,
                                   logic [NODE_W-1:0] root_index, logic [SUM_W-1:0] set_sum);
         set_answer_type wanted;
         if (pending_results.size() == 0) begin
            $error("response arrived with no request outstanding");
            mismatches++;
            return;
         end
         wanted = pending_results.pop_front();
         checked++;
         if (merged !== wanted.merged) begin
            $error("merged: expected %0d, got %0d", wanted.merged, merged);
            mismatches++;
         end
         if (same_set !== wanted.same_set) begin
            $error("same_set: expected %0d, got %0d", wanted.same_set, same_set);
            mismatches++;
         end
         if (root_index !== wanted.root_index) begin
            $error("root_index: expected %0d, got %0d", wanted.root_index, root_index);
            mismatches++;
         end
         if (set_sum !== wanted.set_sum) begin
            $error("set_sum: expected %0d, got %0d", wanted.set_sum, set_sum);
            mismatches++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_opcode = '0;
   logic [NODE_W-1:0]   req_node_a = '0;
   logic [NODE_W-1:0]   req_node_b = '0;
   logic [VALUE_W-1:0]  req_node_value = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_merged;
   logic                rsp_same_set;
   logic [NODE_W-1:0]   rsp_root_index;
   logic [SUM_W-1:0]    rsp_set_sum;

   int                  cycle_count = 0;
   int                  burst_left = 0;
   disjoint_set_scoreboard sb = new();

   union_find_with_set_sums DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_node_a     (req_node_a),
      .req_node_b     (req_node_b),
      .req_node_value (req_node_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_merged     (rsp_merged),
      .rsp_same_set   (rsp_same_set),
      .rsp_root_index (rsp_root_index),
      .rsp_set_sum    (rsp_set_sum)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [NODE_W-1:0] pick_node();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80)
         return NODE_W'($urandom_range(0, 47));
      else if (roll < 90)
         return NODE_W'($urandom_range(1000, 1023));
      else
         return NODE_W'($urandom);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 3);
      if (roll < 2)
         return $urandom;
      else if (roll == 2)
         return VALUE_W'($urandom_range(0, 255));
      else
         return 32'hFFFF_FF00 | VALUE_W'($urandom_range(0, 255));
   endfunction

   // Offers one request and returns once it is accepted; bursts and gaps come from here.
   task automatic offer(input opcode_type op, input logic [NODE_W-1:0] node_a,
                        input logic [NODE_W-1:0] node_b, input logic [VALUE_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_opcode <= op;
      req_node_a <= node_a;
      req_node_b <= node_b;
      req_node_value <= value;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, node_a, node_b, value);
   endtask

   task automatic run_random(input int count);
      int         roll;
      opcode_type op;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 15)
            op = OP_LOAD;
         else if (roll < 55)
            op = OP_UNITE;
         else if (roll < 75)
            op = OP_SAME;
         else
            op = OP_SUM;
         offer(op, pick_node(), pick_node(), pick_value());
      end
   endtask

   // Collects responses and drives rsp_ready from a pattern of its own.
   initial begin
      int  stall_mode;
      int  phase_left;
      int  hold_left;
      bit  held;
      stall_mode = 0;
      phase_left = 0;
      hold_left = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_response(rsp_merged, rsp_same_set, rsp_root_index, rsp_set_sum);
         if (!held && sb.checked == HOLD_AFTER) begin
            held = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               stall_mode = $urandom_range(0, 2);
               phase_left = $urandom_range(20, 100);
            end
            phase_left--;
            case (stall_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      offer(OP_SUM,   10'd0,    10'd1023, 32'h0000_0000);
      offer(OP_LOAD,  10'd0,    10'd1023, 32'hFFFF_FFFF);
      offer(OP_LOAD,  10'd1023, 10'd0,    32'h8000_0001);
      offer(OP_LOAD,  10'd1,    10'd1023, 32'h5555_5555);
      offer(OP_LOAD,  10'd2,    10'd0,    32'hAAAA_AAAA);
      offer(OP_UNITE, 10'd0,    10'd1,    32'hFFFF_FFFF);
      offer(OP_UNITE, 10'd2,    10'd0,    32'h0000_0000);
      offer(OP_UNITE, 10'd0,    10'd0,    32'h0000_0000);
      offer(OP_SAME,  10'd1,    10'd2,    32'h0000_0000);
      offer(OP_SAME,  10'd1,    10'd1023, 32'h0000_0000);
      offer(OP_SUM,   10'd2,    10'd0,    32'h0000_0000);
      offer(OP_UNITE, 10'd1023, 10'd1,    32'h0000_0000);
      offer(OP_LOAD,  10'd1,    10'd1023, 32'h0000_0007);
      offer(OP_SUM,   10'd1,    10'd0,    32'h0000_0000);
      offer(OP_SUM,   10'd0,    10'd0,    32'h0000_0000);
      offer(OP_SAME,  10'd1,    10'd0,    32'h0000_0000);
      offer(OP_UNITE, 10'd1,    10'd0,    32'h0000_0000);
      offer(OP_LOAD,  10'd0,    10'd1023, 32'h0000_0000);
      offer(OP_SUM,   10'd2,    10'd0,    32'h0000_0000);
      offer(OP_SUM,   10'd1023, 10'd1023, 32'h0000_0000);
      offer(OP_SAME,  10'd1023, 10'd2,    32'h0000_0000);

      run_random(RANDOM_ITEMS);

      // The sender waits here until the block has returned every result.
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);

      // A group of nodes takes the largest value and all of them join one set
      // around node 0, which builds a large set with a large sum.
      for (int i = 0; i < CHAIN_NODES; i++)
         offer(OP_LOAD, NODE_W'(i), NODE_W'($urandom), 32'hFFFF_FFFF);
      for (int i = 1; i < CHAIN_NODES; i++)
         offer(OP_UNITE, 10'd0, NODE_W'(i), $urandom);
      offer(OP_LOAD,  10'd5,   10'd0, 32'hFFFF_FFFF);
      offer(OP_UNITE, 10'd5,   10'd0, 32'h0000_0000);
      offer(OP_SUM,   10'd100, 10'd0, 32'h0000_0000);

      run_random(RANDOM_ITEMS);

      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire
